[src/pn3_pkg.sv]
// Shared types and constants for the 3D gradient noise core.
`default_nettype none
package pn3_pkg;

	localparam int DEF_TABLE_SIZE = 256;
	localparam int DEF_FRAC_BITS  = 12;
	localparam int COORD_W        = 24;
	localparam int GRAD_W         = 16;
	localparam int NOISE_W        = 16;
	localparam int FIELD_IDX_W    = 8;
	localparam int QUEUE_DEPTH    = 4;
	localparam int CORNERS        = 8;

	typedef enum logic [1:0] {
		MODE_EVAL    = 2'd0,
		MODE_PERM_WR = 2'd1,
		MODE_GRAD_WR = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_EVAL = 2'd0,
		KIND_PERM = 2'd1,
		KIND_GRAD = 2'd2
	} kind_t;

	typedef struct packed {
		logic  valid;
		kind_t kind;
	} item_ctl_t;

endpackage
`default_nettype wire

[src/perlin_noise_3d_core.sv]
// Top level of the 3D gradient noise core.
// Throughput: one word per cycle; busy stays low in normal use as the back end never stalls.
// An evaluate word passes the front register, the queue, the three chained permutation
// lookups, the gradient read and the multiply-add blend stages before done rises.
// Table writes give no result. Results cannot be held off by the receiver.
// Reset clears only control state; tables hold whatever was last written.
`default_nettype none
module perlin_noise_3d_core #(
	parameter int TABLE_SIZE = pn3_pkg::DEF_TABLE_SIZE,
	parameter int FRAC_BITS  = pn3_pkg::DEF_FRAC_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [1:0]                         mode,
	input  wire logic signed [pn3_pkg::COORD_W-1:0] coord_x,
	input  wire logic signed [pn3_pkg::COORD_W-1:0] coord_y,
	input  wire logic signed [pn3_pkg::COORD_W-1:0] coord_z,
	input  wire logic [pn3_pkg::FIELD_IDX_W-1:0]    entry_index,
	input  wire logic [pn3_pkg::FIELD_IDX_W-1:0]    perm_value,
	input  wire logic signed [pn3_pkg::GRAD_W-1:0]  grad_x,
	input  wire logic signed [pn3_pkg::GRAD_W-1:0]  grad_y,
	input  wire logic signed [pn3_pkg::GRAD_W-1:0]  grad_z,
	output logic                                    done,
	output logic signed [pn3_pkg::NOISE_W-1:0]      noise_value
);
	import pn3_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int PW    = 5 * IDX_W + 3 * FRAC_BITS + 3 * GRAD_W;

	logic                 accept;
	item_ctl_t            front_ctl;
	logic [PW-1:0]        front_data;
	item_ctl_t            queue_ctl;
	logic [PW-1:0]        queue_data;
	logic                 queue_full;
	logic                 eval_valid;
	logic [3*GRAD_W-1:0]  grad_word [CORNERS];
	logic [FRAC_BITS-1:0] frac [3];

	assign busy   = queue_full;
	assign accept = start && !busy;

	pn3_front #(
		.TABLE_SIZE(TABLE_SIZE),
		.FRAC_BITS (FRAC_BITS),
		.PW        (PW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.mode       (mode),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.entry_index(entry_index),
		.perm_value (perm_value),
		.grad_x     (grad_x),
		.grad_y     (grad_y),
		.grad_z     (grad_z),
		.ctl        (front_ctl),
		.payload    (front_data)
	);

	pn3_queue #(
		.W(PW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (front_ctl),
		.in_data (front_data),
		.out_ctl (queue_ctl),
		.out_data(queue_data),
		.full    (queue_full)
	);

	pn3_hash #(
		.TABLE_SIZE(TABLE_SIZE),
		.FRAC_BITS (FRAC_BITS),
		.PW        (PW)
	) u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctl    (queue_ctl),
		.in_data   (queue_data),
		.eval_valid(eval_valid),
		.grad_word (grad_word),
		.frac      (frac)
	);

	pn3_shade #(
		.FRAC_BITS(FRAC_BITS)
	) u_shade (
		.clk        (clk),
		.arst_n     (arst_n),
		.eval_valid (eval_valid),
		.grad_word  (grad_word),
		.frac       (frac),
		.done       (done),
		.noise_value(noise_value)
	);

`ifndef SYNTHESIS
	a_eval_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == 2'(MODE_EVAL)) |-> ##15 done)
		else $error("evaluate word gave no result");

	a_write_gives_none: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode != 2'(MODE_EVAL)) |-> ##15 !done)
		else $error("non-evaluate word gave a result");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("queue backed up although back end never stalls");
`endif

endmodule
`default_nettype wire

[src/pn3_front.sv]
// Front end: accepts words, classifies them and splits coordinates into cell and fraction.
`default_nettype none
module pn3_front #(
	parameter int TABLE_SIZE = pn3_pkg::DEF_TABLE_SIZE,
	parameter int FRAC_BITS  = pn3_pkg::DEF_FRAC_BITS,
	parameter int PW         = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  accept,
	input  wire logic [1:0]                            mode,
	input  wire logic signed [pn3_pkg::COORD_W-1:0]    coord_x,
	input  wire logic signed [pn3_pkg::COORD_W-1:0]    coord_y,
	input  wire logic signed [pn3_pkg::COORD_W-1:0]    coord_z,
	input  wire logic [pn3_pkg::FIELD_IDX_W-1:0]       entry_index,
	input  wire logic [pn3_pkg::FIELD_IDX_W-1:0]       perm_value,
	input  wire logic signed [pn3_pkg::GRAD_W-1:0]     grad_x,
	input  wire logic signed [pn3_pkg::GRAD_W-1:0]     grad_y,
	input  wire logic signed [pn3_pkg::GRAD_W-1:0]     grad_z,
	output pn3_pkg::item_ctl_t                         ctl,
	output logic [PW-1:0]                              payload
);
	import pn3_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int EXT_W = 2 * COORD_W;

	logic signed [COORD_W-1:0] crd [3];
	logic signed [EXT_W-1:0]   ext [3];
	logic [IDX_W-1:0]          cell_idx [3];
	logic [FRAC_BITS-1:0]      frac [3];
	item_ctl_t                 nxt_ctl;
	item_ctl_t                 ctl_q;
	logic [PW-1:0]             payload_q;

	assign crd[0] = coord_x;
	assign crd[1] = coord_y;
	assign crd[2] = coord_z;

	for (genvar k = 0; k < 3; k++) begin : g_axis
		assign ext[k]      = EXT_W'(crd[k]);
		assign cell_idx[k] = ext[k][FRAC_BITS +: IDX_W];
		assign frac[k]     = crd[k][FRAC_BITS-1:0];
	end

	always_comb begin
		nxt_ctl.valid = 1'b0;
		nxt_ctl.kind  = KIND_EVAL;
		unique case (mode)
			MODE_EVAL: begin
				nxt_ctl.valid = accept;
				nxt_ctl.kind  = KIND_EVAL;
			end
			MODE_PERM_WR: begin
				nxt_ctl.valid = accept;
				nxt_ctl.kind  = KIND_PERM;
			end
			MODE_GRAD_WR: begin
				nxt_ctl.valid = accept;
				nxt_ctl.kind  = KIND_GRAD;
			end
			default: begin
				nxt_ctl.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= nxt_ctl;
		end
	end

	always_ff @(posedge clk) begin
		payload_q <= {cell_idx[0], cell_idx[1], cell_idx[2], frac[0], frac[1], frac[2],
			IDX_W'(entry_index), IDX_W'(perm_value), grad_x, grad_y, grad_z};
	end

	assign ctl     = ctl_q;
	assign payload = payload_q;

endmodule
`default_nettype wire

[src/pn3_queue.sv]
// Short queue between front and back ends.
`default_nettype none
module pn3_queue #(
	parameter int W = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pn3_pkg::item_ctl_t in_ctl,
	input  wire logic [W-1:0]       in_data,
	output pn3_pkg::item_ctl_t      out_ctl,
	output logic [W-1:0]            out_data,
	output logic                    full
);
	import pn3_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	kind_t            kind_mem [QUEUE_DEPTH];
	logic [W-1:0]     data_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push = in_ctl.valid;
	assign pop  = (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_mem[wr_ptr_q] <= in_ctl.kind;
			data_mem[wr_ptr_q] <= in_data;
		end
	end

	assign out_ctl.valid = pop;
	assign out_ctl.kind  = kind_mem[rd_ptr_q];
	assign out_data      = data_mem[rd_ptr_q];
	assign full          = (count_q >= CNT_W'(QUEUE_DEPTH - 1));

endmodule
`default_nettype wire

[src/pn3_hash.sv]
// Back end, first half: table writes and corner hashing through replicated tables.
`default_nettype none
module pn3_hash #(
	parameter int TABLE_SIZE = pn3_pkg::DEF_TABLE_SIZE,
	parameter int FRAC_BITS  = pn3_pkg::DEF_FRAC_BITS,
	parameter int PW         = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire pn3_pkg::item_ctl_t              in_ctl,
	input  wire logic [PW-1:0]                   in_data,
	output logic                                 eval_valid,
	output logic [3*pn3_pkg::GRAD_W-1:0]         grad_word [pn3_pkg::CORNERS],
	output logic [FRAC_BITS-1:0]                 frac [3]
);
	import pn3_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int GW_W  = 3 * GRAD_W;

	// stage 1
	logic                 v1_q, v2_q, v3_q, v4_q, v5_q;
	kind_t                kind1_s1, kind2_s2, kind3_s3, kind4_s4;
	logic [IDX_W-1:0]     cell_s1 [3];
	logic [FRAC_BITS-1:0] frac_s1 [3];
	logic [IDX_W-1:0]     idx_s1, pval_s1;
	logic [GW_W-1:0]      g_s1;
	logic [IDX_W-1:0]     ax0, ax1;

	// stage 2
	logic [IDX_W-1:0]     cy_s2, cz_s2, idx_s2, pval_s2;
	logic [FRAC_BITS-1:0] frac_s2 [3];
	logic [GW_W-1:0]      g_s2;
	logic [IDX_W-1:0]     hx_s2 [2];

	// stage 3
	logic [IDX_W-1:0]     cz_s3, idx_s3, pval_s3;
	logic [FRAC_BITS-1:0] frac_s3 [3];
	logic [GW_W-1:0]      g_s3;
	logic [IDX_W-1:0]     hxy_s3 [4];

	// stage 4
	logic [IDX_W-1:0]     idx_s4;
	logic [FRAC_BITS-1:0] frac_s4 [3];
	logic [GW_W-1:0]      g_s4;
	logic [IDX_W-1:0]     hc_s4 [CORNERS];

	// stage 5
	logic [FRAC_BITS-1:0] frac_s5 [3];
	logic [GW_W-1:0]      g_s5 [CORNERS];

	logic perm_wr1, perm_wr2, perm_wr3, grad_wr4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			v1_q <= in_ctl.valid;
			v2_q <= v1_q;
			v3_q <= v2_q;
			v4_q <= v3_q;
			v5_q <= v4_q && (kind4_s4 == KIND_EVAL);
		end
	end

	always_ff @(posedge clk) begin
		kind1_s1 <= in_ctl.kind;
		{cell_s1[0], cell_s1[1], cell_s1[2], frac_s1[0], frac_s1[1], frac_s1[2],
			idx_s1, pval_s1, g_s1} <= in_data;

		kind2_s2 <= kind1_s1;
		cy_s2    <= cell_s1[1];
		cz_s2    <= cell_s1[2];
		frac_s2  <= frac_s1;
		idx_s2   <= idx_s1;
		pval_s2  <= pval_s1;
		g_s2     <= g_s1;

		kind3_s3 <= kind2_s2;
		cz_s3    <= cz_s2;
		frac_s3  <= frac_s2;
		idx_s3   <= idx_s2;
		pval_s3  <= pval_s2;
		g_s3     <= g_s2;

		kind4_s4 <= kind3_s3;
		frac_s4  <= frac_s3;
		idx_s4   <= idx_s3;
		g_s4     <= g_s3;

		frac_s5  <= frac_s4;
	end

	assign perm_wr1 = v1_q && (kind1_s1 == KIND_PERM);
	assign perm_wr2 = v2_q && (kind2_s2 == KIND_PERM);
	assign perm_wr3 = v3_q && (kind3_s3 == KIND_PERM);
	assign grad_wr4 = v4_q && (kind4_s4 == KIND_GRAD);

	assign ax0 = cell_s1[0];
	assign ax1 = cell_s1[0] + IDX_W'(1);

	// x hash: one replica, two reads
	logic [IDX_W-1:0] perm_a_mem [TABLE_SIZE];
	always_ff @(posedge clk) begin
		if (perm_wr1) begin
			perm_a_mem[idx_s1] <= pval_s1;
		end
		hx_s2[0] <= perm_a_mem[ax0];
		hx_s2[1] <= perm_a_mem[ax1];
	end

	// y hash: replica r serves x offset r
	for (genvar r = 0; r < 2; r++) begin : g_perm_b
		logic [IDX_W-1:0] mem [TABLE_SIZE];
		logic [IDX_W-1:0] a0, a1;
		assign a0 = hx_s2[r] + cy_s2;
		assign a1 = hx_s2[r] + cy_s2 + IDX_W'(1);
		always_ff @(posedge clk) begin
			if (perm_wr2) begin
				mem[idx_s2] <= pval_s2;
			end
			hxy_s3[r]     <= mem[a0];
			hxy_s3[r + 2] <= mem[a1];
		end
	end

	// z hash: replica k serves xy corner k
	for (genvar k = 0; k < 4; k++) begin : g_perm_c
		logic [IDX_W-1:0] mem [TABLE_SIZE];
		logic [IDX_W-1:0] a0, a1;
		assign a0 = hxy_s3[k] + cz_s3;
		assign a1 = hxy_s3[k] + cz_s3 + IDX_W'(1);
		always_ff @(posedge clk) begin
			if (perm_wr3) begin
				mem[idx_s3] <= pval_s3;
			end
			hc_s4[k]     <= mem[a0];
			hc_s4[k + 4] <= mem[a1];
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_grad
		logic [GW_W-1:0] mem [TABLE_SIZE];
		always_ff @(posedge clk) begin
			if (grad_wr4) begin
				mem[idx_s4] <= g_s4;
			end
			g_s5[k]     <= mem[hc_s4[k]];
			g_s5[k + 4] <= mem[hc_s4[k + 4]];
		end
	end

	assign eval_valid = v5_q;
	assign grad_word  = g_s5;
	assign frac       = frac_s5;

endmodule
`default_nettype wire

[src/pn3_shade.sv]
// Back end, second half: gradient dot products, smoothstep weights and trilinear blend.
`default_nettype none
module pn3_shade #(
	parameter int FRAC_BITS = pn3_pkg::DEF_FRAC_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                eval_valid,
	input  wire logic [3*pn3_pkg::GRAD_W-1:0]        grad_word [pn3_pkg::CORNERS],
	input  wire logic [FRAC_BITS-1:0]                frac [3],
	output logic                                     done,
	output logic signed [pn3_pkg::NOISE_W-1:0]       noise_value
);
	import pn3_pkg::*;

	localparam int F     = FRAC_BITS;
	localparam int OFF_W = F + 1;
	localparam int PR_W  = OFF_W + GRAD_W;
	localparam int SUM_W = PR_W + 2;
	localparam int DOT_W = SUM_W - F;
	localparam int BV_W  = 20;
	localparam int DF_W  = BV_W + 1;
	localparam int S_W   = F + 2;
	localparam int SP_W  = 2 * F + 2;
	localparam int BP_W  = S_W + 1 + DF_W;
	localparam int SH_W  = BP_W - F;
	localparam logic [S_W-1:0] THREE_ONE = S_W'(3) << F;
	localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(2 ** (NOISE_W - 1) - 1);
	localparam logic signed [SH_W-1:0] SAT_LO = -SAT_HI - SH_W'(1);

	logic v6_q, v7_q, v8_q, v9_q, v10_q, v11_q, v12_q, v13_q;

	logic signed [OFF_W-1:0] off [CORNERS][3];
	logic signed [PR_W-1:0]  prod_s6 [CORNERS][3];
	logic [2*F-1:0]          tt_s6 [3];
	logic [F-1:0]            frac_s6 [3];
	logic signed [DOT_W-1:0] dot_s7 [CORNERS];
	logic [SP_W-1:0]         sp_s7 [3];
	logic [S_W-1:0]          s7 [3];
	logic signed [BP_W-1:0]  bp_s8 [4];
	logic signed [BV_W-1:0]  ba_s8 [4];
	logic [S_W-1:0]          sy_s8, sz_s8, sy_s9, sz_s9, sz_s10, sz_s11;
	logic signed [BV_W-1:0]  lx_s9 [4];
	logic signed [BP_W-1:0]  yp_s10 [2];
	logic signed [BV_W-1:0]  ya_s10 [2];
	logic signed [BV_W-1:0]  ly_s11 [2];
	logic signed [BP_W-1:0]  zp_s12;
	logic signed [BV_W-1:0]  za_s12;
	logic signed [SH_W-1:0]  res;
	logic signed [NOISE_W-1:0] noise_s13;

	for (genvar c = 0; c < CORNERS; c++) begin : g_off
		for (genvar a = 0; a < 3; a++) begin : g_ax
			if (((c >> a) & 1) == 1) begin : g_far
				assign off[c][a] = $signed({1'b1, frac[a]});
			end else begin : g_near
				assign off[c][a] = $signed({1'b0, frac[a]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v6_q  <= 1'b0;
			v7_q  <= 1'b0;
			v8_q  <= 1'b0;
			v9_q  <= 1'b0;
			v10_q <= 1'b0;
			v11_q <= 1'b0;
			v12_q <= 1'b0;
			v13_q <= 1'b0;
		end else begin
			v6_q  <= eval_valid;
			v7_q  <= v6_q;
			v8_q  <= v7_q;
			v9_q  <= v8_q;
			v10_q <= v9_q;
			v11_q <= v10_q;
			v12_q <= v11_q;
			v13_q <= v12_q;
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			s7[a] = sp_s7[a][2*F+1:F];
		end
		res = SH_W'(za_s12) + zp_s12[BP_W-1:F];
	end

	always_ff @(posedge clk) begin
		// corner offsets times gradients, and t squared
		for (int c = 0; c < CORNERS; c++) begin
			for (int a = 0; a < 3; a++) begin
				prod_s6[c][a] <= PR_W'(off[c][a])
					* PR_W'($signed(grad_word[c][(3-a)*GRAD_W-1 -: GRAD_W]));
			end
		end
		for (int a = 0; a < 3; a++) begin
			tt_s6[a]   <= (2*F)'(frac[a]) * (2*F)'(frac[a]);
			frac_s6[a] <= frac[a];
		end

		// dot sums and smoothstep polynomial
		for (int c = 0; c < CORNERS; c++) begin
			dot_s7[c] <= DOT_W'((SUM_W'(prod_s6[c][0]) + SUM_W'(prod_s6[c][1])
				+ SUM_W'(prod_s6[c][2])) >>> F);
		end
		for (int a = 0; a < 3; a++) begin
			sp_s7[a] <= SP_W'(tt_s6[a][2*F-1:F])
				* SP_W'(THREE_ONE - S_W'({frac_s6[a], 1'b0}));
		end

		// blend along x
		for (int p = 0; p < 4; p++) begin
			bp_s8[p] <= BP_W'($signed({1'b0, s7[0]}))
				* BP_W'(DF_W'(dot_s7[2*p+1]) - DF_W'(dot_s7[2*p]));
			ba_s8[p] <= BV_W'(dot_s7[2*p]);
		end
		sy_s8 <= s7[1];
		sz_s8 <= s7[2];

		for (int p = 0; p < 4; p++) begin
			lx_s9[p] <= BV_W'(SH_W'(ba_s8[p]) + bp_s8[p][BP_W-1:F]);
		end
		sy_s9 <= sy_s8;
		sz_s9 <= sz_s8;

		// blend along y
		for (int q = 0; q < 2; q++) begin
			yp_s10[q] <= BP_W'($signed({1'b0, sy_s9}))
				* BP_W'(DF_W'(lx_s9[2*q+1]) - DF_W'(lx_s9[2*q]));
			ya_s10[q] <= lx_s9[2*q];
		end
		sz_s10 <= sz_s9;

		for (int q = 0; q < 2; q++) begin
			ly_s11[q] <= BV_W'(SH_W'(ya_s10[q]) + yp_s10[q][BP_W-1:F]);
		end
		sz_s11 <= sz_s10;

		// blend along z
		zp_s12 <= BP_W'($signed({1'b0, sz_s11}))
			* BP_W'(DF_W'(ly_s11[1]) - DF_W'(ly_s11[0]));
		za_s12 <= ly_s11[0];

		priority if (res > SAT_HI) begin
			noise_s13 <= SAT_HI[NOISE_W-1:0];
		end else if (res < SAT_LO) begin
			noise_s13 <= SAT_LO[NOISE_W-1:0];
		end else begin
			noise_s13 <= res[NOISE_W-1:0];
		end
	end

	assign done        = v13_q;
	assign noise_value = noise_s13;

endmodule
`default_nettype wire
